FILE: rtl/spiee_pkg.sv
// Shared types and constants for the SPI EEPROM page write sequencer.
`default_nettype none
package spiee_pkg;

  localparam int MAX_RES = 10;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  localparam logic [1:0] CMD_DATA_BYTE  = 2'd0;
  localparam logic [1:0] CMD_READ_START = 2'd1;
  localparam logic [1:0] CMD_STATUS     = 2'd2;

  localparam logic [2:0] K_SEND    = 3'd0;
  localparam logic [2:0] K_RECV    = 3'd1;
  localparam logic [2:0] K_REL     = 3'd2;
  localparam logic [2:0] K_DONE    = 3'd3;
  localparam logic [2:0] K_TIMEOUT = 3'd4;

  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam int         SR_WIP   = 0;

  localparam logic [15:0] POLL_LIMIT_RESET = 16'd50000;
  localparam logic [15:0] POLLS_MAX        = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_OPEN    = 2'd1,
    PH_POLL    = 2'd2,
    PH_BETWEEN = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] length;
    logic        last;
  } request_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [15:0] count;
    logic        final_res;
  } action_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] next_address;
    logic [15:0] polls_done;
    logic        request_ended;
    logic        dropping;
  } seq_state_t;

endpackage
`default_nettype wire

FILE: rtl/spi_eeprom_page_write_sequencer.sv
// Top level of the SPI EEPROM page write sequencer.
//
// The request channel (request_valid, request_stall, request) carries write data
// bytes, read starts and status replies from the part. The action channel
// (action_valid, action_stall, action) delivers the SPI actions that each request
// causes, one per cycle while action_stall is low, with final_res set on the last
// one of a request. The poll limit register is written through cfg_valid,
// cfg_ready and cfg_data; cfg_ready is always high.
//
// A request is taken into an input register, decoded combinationally into a list
// of up to nine actions, and the list is shifted out of an action buffer. With the
// action buffer free, the first action is valid once the request has passed the
// input register and been loaded into the action buffer. A request that causes n
// actions occupies the action buffer until its last action is taken; the next
// request is decoded in the cycle its predecessor's last action is taken. A
// request that causes no action leaves the buffer empty. When the receiver stalls,
// the current action holds, the input register fills, then request_stall rises.
//
// Reset clears the sequencer to idle with no request open, empties both stages
// and restores the poll limit to 50000.
`default_nettype none
module spi_eeprom_page_write_sequencer #(
  parameter int PAGE_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                request_valid,
  output logic                request_stall,
  input  spiee_pkg::request_t request,
  output logic                action_valid,
  input  logic                action_stall,
  output spiee_pkg::action_t  action,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import spiee_pkg::*;

  logic                 req_full;
  request_t             req_q;
  seq_state_t           st;
  seq_state_t           st_next;
  logic [15:0]          poll_limit;
  action_t              list [MAX_RES];
  action_t              res [MAX_RES];
  logic [RES_CNT_W-1:0] res_n;
  logic [RES_CNT_W-1:0] remaining;
  logic                 take;
  logic                 list_free;
  logic                 advance;
  logic                 accept_req;

  spiee_step #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_step (
    .req       (req_q),
    .st        (st),
    .poll_limit(poll_limit),
    .st_next   (st_next),
    .res       (res),
    .res_n     (res_n)
  );

  assign cfg_ready = 1'b1;
  assign action_valid = (remaining != '0);
  assign action = list[0];
  assign take = action_valid && !action_stall;
  assign list_free = (remaining == '0) || ((remaining == RES_CNT_W'(1)) && take);
  assign advance = req_full && list_free;
  assign request_stall = req_full && !advance;
  assign accept_req = request_valid && !request_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
      remaining <= '0;
      poll_limit <= POLL_LIMIT_RESET;
      st.phase <= PH_IDLE;
      st.next_address <= 16'd0;
      st.polls_done <= 16'd0;
      st.request_ended <= 1'b0;
      st.dropping <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        poll_limit <= cfg_data;
      end
      if (accept_req) begin
        req_full <= 1'b1;
      end else if (advance) begin
        req_full <= 1'b0;
      end
      if (advance) begin
        st <= st_next;
        remaining <= res_n;
      end else if (take) begin
        remaining <= remaining - RES_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_req) begin
      req_q <= request;
    end
    if (advance) begin
      list <= res;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        list[i] <= list[i + 1];
      end
    end
  end

  a_remaining_bound: assert property (@(posedge clk) disable iff (rst)
    remaining <= RES_CNT_W'(MAX_RES))
    else $error("action buffer count out of range");

  a_advance_only_when_free: assert property (@(posedge clk) disable iff (rst)
    advance |-> (remaining == '0) || (remaining == RES_CNT_W'(1) && take))
    else $error("request decoded while actions still pending");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req_full |-> !request_stall)
    else $error("request stalled with empty input register");

  a_drop_only_idle: assert property (@(posedge clk) disable iff (rst)
    st.dropping |-> st.phase == PH_IDLE)
    else $error("dropping outside idle phase");

  a_polls_only_polling: assert property (@(posedge clk) disable iff (rst)
    (st.polls_done != 16'd0) |-> st.phase == PH_POLL)
    else $error("poll count held outside polling phase");

endmodule
`default_nettype wire

FILE: rtl/spiee_step.sv
// Combinational decode of one request into its SPI actions and the next sequencer state.
`default_nettype none
module spiee_step #(
  parameter int PAGE_BYTES = 64
) (
  input  spiee_pkg::request_t   req,
  input  spiee_pkg::seq_state_t st,
  input  logic [15:0]           poll_limit,
  output spiee_pkg::seq_state_t st_next,
  output spiee_pkg::action_t    res [spiee_pkg::MAX_RES],
  output logic [spiee_pkg::RES_CNT_W-1:0] res_n
);
  import spiee_pkg::*;

  function automatic int trail_zeros(int p);
    int k;
    k = 0;
    for (int i = 0; i < 16; i++) begin
      if (((p >> i) & 1) == 0 && k == i) begin
        k = i + 1;
      end
    end
    return k;
  endfunction

  function automatic logic [15:0] inv16(logic [15:0] d);
    logic [15:0] x;
    x = d;
    for (int i = 0; i < 4; i++) begin
      x = x * (16'd2 - d * x);
    end
    return x;
  endfunction

  function automatic action_t mk(logic [2:0] kind, logic [7:0] value, logic [15:0] count);
    action_t r;
    r.kind = kind;
    r.value = value;
    r.count = count;
    r.final_res = 1'b0;
    return r;
  endfunction

  // A page boundary test as an odd-factor divisibility check by modular inverse.
  localparam int          TZ       = trail_zeros(PAGE_BYTES);
  localparam int          ODD      = PAGE_BYTES >> TZ;
  localparam logic [15:0] LOW_MASK = 16'((1 << TZ) - 1);
  localparam logic [15:0] INV      = inv16(16'(ODD));
  localparam logic [15:0] LIM      = 16'(65535 / ODD);

  logic [15:0] a;
  logic [15:0] a_inc;
  logic [15:0] prod;
  logic        boundary;
  logic [15:0] polls_inc;

  always_comb begin
    a = (st.phase == PH_IDLE) ? req.addr : st.next_address;
    a_inc = a + 16'd1;
    prod = (a_inc >> TZ) * INV;
    boundary = ((a_inc & LOW_MASK) == 16'd0) && (prod <= LIM);
    polls_inc = (st.polls_done < POLLS_MAX) ? st.polls_done + 16'd1 : st.polls_done;
  end

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end
    res_n = '0;
    st_next = st;
    case (req.cmd)
      CMD_DATA_BYTE: begin
        if (st.dropping) begin
          if (req.last) begin
            st_next.dropping = 1'b0;
          end
        end else if (st.phase != PH_POLL) begin
          if (st.phase == PH_IDLE || st.phase == PH_BETWEEN) begin
            res[0] = mk(K_SEND, OP_WREN, 16'd0);
            res[1] = mk(K_REL, 8'd0, 16'd0);
            res[2] = mk(K_SEND, OP_WRITE, 16'd0);
            res[3] = mk(K_SEND, a[15:8], 16'd0);
            res[4] = mk(K_SEND, a[7:0], 16'd0);
            res_n = RES_CNT_W'(5);
          end
          res[res_n[RES_IDX_W-1:0]] = mk(K_SEND, req.data, 16'd0);
          res_n = res_n + RES_CNT_W'(1);
          st_next.next_address = a_inc;
          st_next.phase = PH_OPEN;
          if (req.last || boundary) begin
            res[res_n[RES_IDX_W-1:0]] = mk(K_REL, 8'd0, 16'd0);
            res[res_n[RES_IDX_W-1:0] + RES_IDX_W'(1)] = mk(K_SEND, OP_RDSR, 16'd0);
            res[res_n[RES_IDX_W-1:0] + RES_IDX_W'(2)] = mk(K_RECV, 8'd0, 16'd1);
            res_n = res_n + RES_CNT_W'(3);
            st_next.request_ended = req.last;
            st_next.polls_done = 16'd0;
            st_next.phase = PH_POLL;
          end
        end
      end
      CMD_READ_START: begin
        if (st.phase == PH_IDLE) begin
          res[0] = mk(K_SEND, OP_READ, 16'd0);
          res[1] = mk(K_SEND, req.addr[15:8], 16'd0);
          res[2] = mk(K_SEND, req.addr[7:0], 16'd0);
          res[3] = mk(K_RECV, 8'd0, req.length);
          res[4] = mk(K_REL, 8'd0, 16'd0);
          res_n = RES_CNT_W'(5);
        end
      end
      CMD_STATUS: begin
        if (st.phase == PH_POLL) begin
          res[0] = mk(K_REL, 8'd0, 16'd0);
          if (!req.data[SR_WIP]) begin
            res_n = RES_CNT_W'(1);
            if (st.request_ended) begin
              res[1] = mk(K_DONE, 8'd0, 16'd0);
              res_n = RES_CNT_W'(2);
              st_next.phase = PH_IDLE;
            end else begin
              st_next.phase = PH_BETWEEN;
            end
            st_next.polls_done = 16'd0;
          end else if (polls_inc >= poll_limit) begin
            res[1] = mk(K_TIMEOUT, 8'd0, 16'd0);
            res_n = RES_CNT_W'(2);
            st_next.dropping = !st.request_ended;
            st_next.phase = PH_IDLE;
            st_next.polls_done = 16'd0;
          end else begin
            res[1] = mk(K_SEND, OP_RDSR, 16'd0);
            res[2] = mk(K_RECV, 8'd0, 16'd1);
            res_n = RES_CNT_W'(3);
            st_next.polls_done = polls_inc;
          end
        end
      end
      default: begin
      end
    endcase
    if (res_n != '0) begin
      res[res_n[RES_IDX_W-1:0] - RES_IDX_W'(1)].final_res = 1'b1;
    end
  end

endmodule
`default_nettype wire
